// ----- design/ffa_pkg.sv -----
// shared types and codes for the first-fit free-list allocator
`timescale 1ns / 1ps
package ffa_pkg;

  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_DEFRAG = 2'd2;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_AREAD  = 13'b0000000000010,
    ST_ACHK   = 13'b0000000000100,
    ST_SHREAD = 13'b0000000001000,
    ST_SHWR   = 13'b0000000010000,
    ST_SOUTER = 13'b0000000100000,
    ST_SKEY   = 13'b0000001000000,
    ST_SRD    = 13'b0000010000000,
    ST_SCMP   = 13'b0000100000000,
    ST_MRD    = 13'b0001000000000,
    ST_MCHK   = 13'b0010000000000,
    ST_DONE   = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_t;

endpackage

// ----- design/ffa_table_ram.sv -----
// free-block table memory: one write port, one registered read port
`timescale 1ns / 1ps
module ffa_table_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/first_fit_free_list_allocator.sv -----
// top level of the first-fit free-list allocator
`timescale 1ns / 1ps
// The free-block table (start, length) sits in one synchronous RAM, and one
// item is handled at a time. Free passes from its transfer through the done
// state to the result register. Allocate reads the entries one by one from
// the front and takes the first that fits; an exact fit then closes the table
// up by moving each later entry down one place. Defragment is a stable
// insertion sort by start address done through the one RAM, then a merge
// pass that joins adjacent blocks. The result is held in an output register;
// a new item is taken once it has transferred.
module first_fit_free_list_allocator #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_block_addr,
  input  logic [15:0] in_block_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_granted_addr,
  output logic        out_success,
  output logic        out_table_full
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = ADDR_BITS + 1;
  localparam int EW = ADDR_BITS + LW;
  localparam logic [LW-1:0] LEN_MAX = '1;

  ffa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [15:0] len_r, len_nxt;
  logic [ADDR_BITS-1:0] key_s_r, key_s_nxt, ps_r, ps_nxt;
  logic [LW-1:0] key_l_r, key_l_nxt, pl_r, pl_nxt;
  logic [15:0] ga_r, ga_nxt;
  logic ok_r, ok_nxt, full_r, full_nxt, ov_r, ov_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [ADDR_BITS-1:0] rs;
  logic [LW-1:0] rl;
  logic [ADDR_BITS+1:0] pend;
  logic [LW:0] psum;
  logic [CW-1:0] ridx;

  ffa_table_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rs = rdata[EW-1:LW];
  assign rl = rdata[LW-1:0];
  assign raddr = ridx[IW-1:0];
  assign pend = {2'b00, ps_r} + {1'b0, pl_r};
  assign psum = {1'b0, pl_r} + {1'b0, rl};

  assign in_ready = state_r == ffa_pkg::ST_IDLE;
  assign out_valid = ov_r;
  assign out_granted_addr = ga_r;
  assign out_success = ok_r;
  assign out_table_full = full_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; i_nxt = i_r; j_nxt = j_r; p_nxt = p_r;
    len_nxt = len_r; key_s_nxt = key_s_r; key_l_nxt = key_l_r; ps_nxt = ps_r;
    pl_nxt = pl_r; ga_nxt = ga_r; ok_nxt = ok_r; full_nxt = full_r; ov_nxt = ov_r;
    we = 1'b0; waddr = i_r[IW-1:0]; wdata = '0; ridx = i_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ffa_pkg::ST_IDLE: begin
        if (in_valid) begin
          len_nxt = in_block_len; ga_nxt = '0; ok_nxt = 1'b0; full_nxt = 1'b0;
          i_nxt = '0;
          state_nxt = ffa_pkg::ST_DONE;
          case (in_kind)
            ffa_pkg::KIND_FREE: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                full_nxt = 1'b1;
              end else begin
                we = 1'b1; waddr = count_r[IW-1:0];
                wdata = {ADDR_BITS'(in_block_addr), LW'(in_block_len)};
                count_nxt = count_r + 1'b1; ok_nxt = 1'b1;
              end
            end
            ffa_pkg::KIND_ALLOC: begin
              if (in_block_len != '0) state_nxt = ffa_pkg::ST_AREAD;
            end
            ffa_pkg::KIND_DEFRAG: begin
              ok_nxt = 1'b1;
              if (count_r > CW'(1)) begin
                i_nxt = CW'(1); state_nxt = ffa_pkg::ST_SOUTER;
              end
            end
            default: ;
          endcase
        end
      end
      ffa_pkg::ST_AREAD: begin
        if (i_r >= count_r) state_nxt = ffa_pkg::ST_DONE;
        else state_nxt = ffa_pkg::ST_ACHK;
      end
      ffa_pkg::ST_ACHK: begin
        if (rl >= LW'(len_r)) begin
          ga_nxt = 16'(rs); ok_nxt = 1'b1;
          if (rl > LW'(len_r)) begin
            we = 1'b1;
            wdata = {rs + ADDR_BITS'(len_r), rl - LW'(len_r)};
            state_nxt = ffa_pkg::ST_DONE;
          end else begin
            count_nxt = count_r - 1'b1;
            j_nxt = i_r + 1'b1;
            state_nxt = ffa_pkg::ST_SHREAD;
          end
        end else begin
          i_nxt = i_r + 1'b1; ridx = i_r + 1'b1;
          state_nxt = ffa_pkg::ST_AREAD;
        end
      end
      ffa_pkg::ST_SHREAD: begin
        ridx = j_r;
        if (j_r > count_r) state_nxt = ffa_pkg::ST_DONE;
        else state_nxt = ffa_pkg::ST_SHWR;
      end
      ffa_pkg::ST_SHWR: begin
        we = 1'b1; waddr = IW'(j_r - 1'b1); wdata = rdata;
        j_nxt = j_r + 1'b1;
        state_nxt = ffa_pkg::ST_SHREAD;
      end
      ffa_pkg::ST_SOUTER: begin
        if (i_r >= count_r) begin
          p_nxt = '0; ridx = '0; i_nxt = CW'(1);
          state_nxt = ffa_pkg::ST_MRD;
        end else begin
          state_nxt = ffa_pkg::ST_SKEY;
        end
      end
      ffa_pkg::ST_SKEY: begin
        key_s_nxt = rs; key_l_nxt = rl; j_nxt = i_r;
        ridx = i_r - 1'b1;
        state_nxt = ffa_pkg::ST_SCMP;
      end
      ffa_pkg::ST_SRD: begin
        ridx = j_r - 1'b1;
        state_nxt = ffa_pkg::ST_SCMP;
      end
      ffa_pkg::ST_SCMP: begin
        if (j_r != '0 && rs > key_s_r) begin
          we = 1'b1; waddr = j_r[IW-1:0]; wdata = rdata;
          j_nxt = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            j_nxt = '0;
            state_nxt = ffa_pkg::ST_SCMP;
          end else begin
            state_nxt = ffa_pkg::ST_SRD;
          end
        end else begin
          we = 1'b1; waddr = j_r[IW-1:0]; wdata = {key_s_r, key_l_r};
          i_nxt = i_r + 1'b1; ridx = i_r + 1'b1;
          state_nxt = ffa_pkg::ST_SOUTER;
        end
      end
      ffa_pkg::ST_MRD: begin
        if (p_r == '0 && i_r == CW'(1)) begin
          ps_nxt = rs; pl_nxt = rl;
        end
        ridx = i_r;
        if (i_r >= count_r) begin
          we = 1'b1; waddr = p_r[IW-1:0]; wdata = {ps_r, pl_r};
          if (p_r == '0 && i_r == CW'(1)) wdata = rdata;
          count_nxt = p_r + 1'b1;
          state_nxt = ffa_pkg::ST_DONE;
        end else begin
          state_nxt = ffa_pkg::ST_MCHK;
        end
      end
      ffa_pkg::ST_MCHK: begin
        if (pend == {2'b00, rs}) begin
          pl_nxt = psum[LW] ? LEN_MAX : psum[LW-1:0];
        end else begin
          we = 1'b1; waddr = p_r[IW-1:0]; wdata = {ps_r, pl_r};
          p_nxt = p_r + 1'b1; ps_nxt = rs; pl_nxt = rl;
        end
        i_nxt = i_r + 1'b1; ridx = i_r + 1'b1;
        state_nxt = ffa_pkg::ST_MRD;
      end
      ffa_pkg::ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          state_nxt = ffa_pkg::ST_OUT;
        end
      end
      ffa_pkg::ST_OUT: begin
        if (!ov_r || out_ready) state_nxt = ffa_pkg::ST_IDLE;
      end
      default: state_nxt = ffa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::ST_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; p_r <= p_nxt; len_r <= len_nxt;
    key_s_r <= key_s_nxt; key_l_r <= key_l_nxt; ps_r <= ps_nxt; pl_r <= pl_nxt;
    ga_r <= ga_nxt; ok_r <= ok_nxt; full_r <= full_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count past depth");
  a_full_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_success && out_table_full)) else $error("full with success");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_success) |-> out_granted_addr == '0) else $error("grant on failure");
  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready || out_ready || state_r == ffa_pkg::ST_IDLE)
    else $error("ready while busy");

endmodule

// ----- dv/first_fit_free_list_allocator_tb.sv -----
// self-checking testbench for the first-fit free-list allocator
`timescale 1ns / 1ps
module first_fit_free_list_allocator_tb;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 64'd50000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] granted_addr;
    logic        success;
    logic        table_full;
  } grant_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] len;
    bit          typed;
    grant_t      res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [15:0] in_block_addr = '0;
  logic [15:0] in_block_len = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_granted_addr;
  logic out_success;
  logic out_table_full;

  logic [15:0] blk_start [DEPTH];
  logic [16:0] blk_len [DEPTH];
  int blk_count;
  grant_t pending_grants[$];
  row_t rows[$];
  int errors;
  longint cycles;
  int send_idle;
  int recv_idle;
  bit recv_hold;

  first_fit_free_list_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_block_addr(in_block_addr), .in_block_len(in_block_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_granted_addr(out_granted_addr), .out_success(out_success),
    .out_table_full(out_table_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic grant_t predict_grant(logic [1:0] kind, logic [15:0] addr,
                                           logic [15:0] len);
    grant_t r;
    logic [15:0] ks;
    logic [16:0] kl;
    logic [17:0] sum;
    int j;
    int prev;
    r = '0;
    case (kind)
      ffa_pkg::KIND_FREE: begin
        if (blk_count >= DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          blk_start[blk_count] = addr;
          blk_len[blk_count] = {1'b0, len};
          blk_count++;
          r.success = 1'b1;
        end
      end
      ffa_pkg::KIND_ALLOC: begin
        if (len != 0) begin
          for (int i = 0; i < blk_count; i++) begin
            if (blk_len[i] >= {1'b0, len}) begin
              r.granted_addr = blk_start[i];
              r.success = 1'b1;
              if (blk_len[i] > {1'b0, len}) begin
                blk_start[i] = blk_start[i] + len;
                blk_len[i] = blk_len[i] - len;
              end else begin
                for (int k = i + 1; k < blk_count; k++) begin
                  blk_start[k-1] = blk_start[k];
                  blk_len[k-1] = blk_len[k];
                end
                blk_count--;
              end
              break;
            end
          end
        end
      end
      ffa_pkg::KIND_DEFRAG: begin
        r.success = 1'b1;
        if (blk_count > 1) begin
          for (int i = 1; i < blk_count; i++) begin
            ks = blk_start[i];
            kl = blk_len[i];
            j = i;
            while (j > 0 && blk_start[j-1] > ks) begin
              blk_start[j] = blk_start[j-1];
              blk_len[j] = blk_len[j-1];
              j--;
            end
            blk_start[j] = ks;
            blk_len[j] = kl;
          end
          prev = 0;
          for (int i = 1; i < blk_count; i++) begin
            if ({1'b0, blk_start[prev]} + {1'b0, blk_len[prev]} == {2'b0, blk_start[i]}) begin
              sum = {1'b0, blk_len[prev]} + {1'b0, blk_len[i]};
              blk_len[prev] = sum[17] ? 17'h1ffff : sum[16:0];
            end else begin
              prev++;
              blk_start[prev] = blk_start[i];
              blk_len[prev] = blk_len[i];
            end
          end
          blk_count = prev + 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [15:0] addr, logic [15:0] len,
                           bit typed, grant_t res);
    grant_t p;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    p = predict_grant(kind, addr, len);
    if (typed && p != res) begin
      $error("typed row disagrees: expected %h predicted %h", res, p);
      errors++;
    end
    pending_grants.push_back(p);
    in_valid = 1'b1;
    in_kind = kind;
    in_block_addr = addr;
    in_block_len = len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  task automatic random_item(int mode);
    logic [1:0] k;
    logic [15:0] a;
    logic [15:0] l;
    int pick;
    pick = $urandom_range(99);
    a = 16'($urandom);
    l = 16'($urandom);
    if (mode == 0) begin
      a = a & 16'h00ff;
      l = 16'($urandom_range(16));
    end
    if (pick < 45) k = ffa_pkg::KIND_FREE;
    else if (pick < 85) k = ffa_pkg::KIND_ALLOC;
    else if (pick < 93) k = ffa_pkg::KIND_DEFRAG;
    else if (pick < 96) k = KIND_UNUSED;
    else begin
      k = ffa_pkg::KIND_ALLOC;
      l = 16'd0;
    end
    if (k == ffa_pkg::KIND_ALLOC && mode == 0 && l == 16'd0 && pick < 96) l = 16'd1;
    send_item(k, a, l, 1'b0, '0);
  endtask

  task automatic add_row(logic [1:0] k, logic [15:0] a, logic [15:0] l, bit t,
                         logic [15:0] ga, logic s, logic f);
    row_t r;
    r.kind = k; r.addr = a; r.len = l; r.typed = t;
    r.res = '{granted_addr: ga, success: s, table_full: f};
    rows.push_back(r);
  endtask

  always @(negedge clk) begin
    if (recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected transfer on result channel");
          errors++;
        end else begin
          g = pending_grants.pop_front();
          if (out_granted_addr !== g.granted_addr) begin
            $error("granted_addr expected %h actual %h", g.granted_addr, out_granted_addr);
            errors++;
          end
          if (out_success !== g.success) begin
            $error("success expected %b actual %b", g.success, out_success);
            errors++;
          end
          if (out_table_full !== g.table_full) begin
            $error("table_full expected %b actual %b", g.table_full, out_table_full);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    blk_count = 0;
    send_idle = 0;
    recv_idle = 0;
    recv_hold = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0001, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_DEFRAG, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'h1000, 16'h0010, 1'b1, 16'h0000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_DEFRAG, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0011, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0004, 1'b1, 16'h1000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h000c, 1'b1, 16'h1004, 1'b1, 1'b0);
    add_row(KIND_UNUSED, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0002, 1'b1, 16'hffff, 1'b1, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'h8000, 16'h8000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'h0000, 16'h8000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'h0000, 16'hffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_FREE, 16'hffff, 16'hffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_DEFRAG, 16'h0000, 16'h0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'hffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'hffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(ffa_pkg::KIND_ALLOC, 16'h0000, 16'h0001, 1'b0, '0, 1'b0, 1'b0);
    foreach (rows[i]) send_item(rows[i].kind, rows[i].addr, rows[i].len,
                                rows[i].typed, rows[i].res);
    drain();

    // fill the table past capacity so that the last frees are refused, then a full defrag
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(ffa_pkg::KIND_FREE, 16'($urandom),
                $urandom_range(3) == 0 ? 16'd0 : 16'($urandom), 1'b0, '0);
    send_item(ffa_pkg::KIND_DEFRAG, 16'd0, 16'd0, 1'b0, '0);
    drain();
    for (int i = 0; i < 40; i++)
      send_item(ffa_pkg::KIND_ALLOC, 16'd0, 16'($urandom), 1'b0, '0);
    drain();

    send_idle = 27;
    recv_idle = 54;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(i % 4 == 3);
    drain();

    send_idle = 54;
    recv_idle = 27;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(i % 4 == 3);

    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(negedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_item(0);
    join
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(i % 4 == 3);
    drain();
    repeat (5000) @(negedge clk);

    if (errors == 0 && pending_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ffa_pkg.sv
design/ffa_table_ram.sv
design/first_fit_free_list_allocator.sv
dv/first_fit_free_list_allocator_tb.sv
